/* hw/rtl/lpp_pkg.sv */
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants for the lidar point to pixel projection pipeline.
// ----------------------------------------------------------------------------
package lpp_pkg;

    localparam int COORD_WIDTH_DEF       = 19;
    localparam int COEF_FRAC_BITS_DEF    = 12;
    localparam int PIXEL_INDEX_WIDTH_DEF = 12;

    localparam int ACC_WIDTH   = 64;
    localparam int MAG_WIDTH   = 63;
    localparam int SUMSQ_WIDTH = 32;
    localparam int RANGE_WIDTH = 16;
    localparam int SIZE_WIDTH  = 13;
    localparam int CFG_IDX_WIDTH = 4;

    localparam logic [31:0] RANGE_SQ_MAX = 32'hFFFE_0001;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_U_XY   = 4'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_U_ZO   = 4'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_V_XY   = 4'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_V_ZO   = 4'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_W_XY   = 4'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_W_ZO   = 4'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_HEIGHT = 4'd7;

    localparam logic [SIZE_WIDTH-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [SIZE_WIDTH-1:0] HEIGHT_RESET = 13'd1080;

    typedef logic [5:0][63:0] proj_coef_t;

    typedef struct packed {
        logic valid;
        logic col_ok;
        logic row_ok;
        logic sat;
    } step_flags_t;

endpackage

/* hw/rtl/lpp_front.sv */
// ----------------------------------------------------------------------------
// lpp_front
// Axis remap, projection products, homogeneous sums and squared range,
// then divide setup. Four register stages.
// ----------------------------------------------------------------------------
module lpp_front #(
    parameter int COORD_WIDTH = lpp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [COORD_WIDTH-1:0]          px,
    input  logic signed [COORD_WIDTH-1:0]          py,
    input  logic signed [COORD_WIDTH-1:0]          pz,
    input  lpp_pkg::proj_coef_t                    coef,
    output lpp_pkg::step_flags_t                   flags_out,
    output logic [lpp_pkg::MAG_WIDTH-1:0]          rem_u,
    output logic [lpp_pkg::MAG_WIDTH-1:0]          rem_v,
    output logic [lpp_pkg::MAG_WIDTH-1:0]          div_w,
    output logic [lpp_pkg::SUMSQ_WIDTH-1:0]        sumsq
);

    localparam int CXW  = COORD_WIDTH + 1;
    localparam int AW   = lpp_pkg::ACC_WIDTH;
    localparam int SQW0 = 2 * COORD_WIDTH + 2;
    localparam int SQW  = (SQW0 > 33) ? SQW0 : 33;

    // stage 1: remap and magnitudes
    logic                           v1_reg;
    logic signed [CXW-1:0]          cx_reg, cy_reg, cz_reg;
    logic [COORD_WIDTH-1:0]         ax_reg, ay_reg, az_reg;

    // stage 2: products
    logic                           v2_reg;
    logic signed [AW-1:0]           prod_reg [9];
    logic signed [AW-1:0]           off_reg [3];
    logic [2*COORD_WIDTH-1:0]       sq_reg [3];

    // stage 3: sums
    logic                           v3_reg;
    logic signed [AW-1:0]           u_reg, v_reg, w_reg;
    logic [SQW-1:0]                 ss_reg;

    // stage 4: divide setup
    lpp_pkg::step_flags_t           f4_reg;
    logic [lpp_pkg::MAG_WIDTH-1:0]  ru_reg, rv_reg, w4_reg;
    logic [lpp_pkg::SUMSQ_WIDTH-1:0] s4_reg;

    logic [COORD_WIDTH-1:0]         ax_next, ay_next, az_next;
    logic signed [CXW-1:0]          cmul [3];
    logic [SQW-1:0]                 ss_next;
    logic                           w_pos;
    logic [AW-1:0]                  neg_u, neg_v;

    assign ax_next = px[COORD_WIDTH-1] ? COORD_WIDTH'(-px) : px;
    assign ay_next = py[COORD_WIDTH-1] ? COORD_WIDTH'(-py) : py;
    assign az_next = pz[COORD_WIDTH-1] ? COORD_WIDTH'(-pz) : pz;

    assign cmul[0] = cx_reg;
    assign cmul[1] = cy_reg;
    assign cmul[2] = cz_reg;

    assign ss_next = SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);

    assign w_pos = !w_reg[AW-1] && (|w_reg);
    assign neg_u = AW'(0) - u_reg;
    assign neg_v = AW'(0) - v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            f4_reg <= '0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            f4_reg.valid  <= v3_reg;
            // negative numerator: quotient truncates to zero only below one divisor
            f4_reg.col_ok <= w_pos && (!u_reg[AW-1] || (neg_u < w_reg));
            f4_reg.row_ok <= w_pos && (!v_reg[AW-1] || (neg_v < w_reg));
            f4_reg.sat    <= ss_reg > SQW'(lpp_pkg::RANGE_SQ_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg <= -CXW'(py);
            cy_reg <= -CXW'(pz);
            cz_reg <= CXW'(px);
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            az_reg <= az_next;

            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (c < 2) begin
                        prod_reg[r*3+c] <= AW'(cmul[c] *
                            $signed(coef[2*r][32*c +: 32]));
                    end else begin
                        prod_reg[r*3+c] <= AW'(cmul[c] *
                            $signed(coef[2*r+1][31:0]));
                    end
                end
                off_reg[r] <= AW'($signed(coef[2*r+1][63:32]));
            end
            sq_reg[0] <= ax_reg * ax_reg;
            sq_reg[1] <= ay_reg * ay_reg;
            sq_reg[2] <= az_reg * az_reg;

            u_reg  <= prod_reg[0] + prod_reg[1] + prod_reg[2] + off_reg[0];
            v_reg  <= prod_reg[3] + prod_reg[4] + prod_reg[5] + off_reg[1];
            w_reg  <= prod_reg[6] + prod_reg[7] + prod_reg[8] + off_reg[2];
            ss_reg <= ss_next;

            ru_reg <= u_reg[AW-1] ? '0 : u_reg[lpp_pkg::MAG_WIDTH-1:0];
            rv_reg <= v_reg[AW-1] ? '0 : v_reg[lpp_pkg::MAG_WIDTH-1:0];
            w4_reg <= w_reg[lpp_pkg::MAG_WIDTH-1:0];
            s4_reg <= ss_reg[lpp_pkg::SUMSQ_WIDTH-1:0];
        end
    end

    assign flags_out = f4_reg;
    assign rem_u     = ru_reg;
    assign rem_v     = rv_reg;
    assign div_w     = w4_reg;
    assign sumsq     = s4_reg;

endmodule

/* hw/rtl/lpp_step.sv */
// ----------------------------------------------------------------------------
// lpp_step
// One pipeline step: one quotient bit for column and row (the first step only
// checks the quotients for overflow) and one root bit for the range, while bits remain.
// ----------------------------------------------------------------------------
module lpp_step #(
    parameter int PIXEL_INDEX_WIDTH = lpp_pkg::PIXEL_INDEX_WIDTH_DEF,
    parameter int STAGE             = 0
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  lpp_pkg::step_flags_t                  flags_in,
    input  logic [lpp_pkg::MAG_WIDTH-1:0]         rem_u_in,
    input  logic [lpp_pkg::MAG_WIDTH-1:0]         rem_v_in,
    input  logic [lpp_pkg::MAG_WIDTH-1:0]         w_in,
    input  logic [PIXEL_INDEX_WIDTH-1:0]          col_in,
    input  logic [PIXEL_INDEX_WIDTH-1:0]          row_in,
    input  logic [lpp_pkg::SUMSQ_WIDTH-1:0]       s_in,
    input  logic [lpp_pkg::RANGE_WIDTH-1:0]       root_in,
    input  logic [lpp_pkg::SUMSQ_WIDTH-1:0]       rsq_in,
    output lpp_pkg::step_flags_t                  flags_out,
    output logic [lpp_pkg::MAG_WIDTH-1:0]         rem_u_out,
    output logic [lpp_pkg::MAG_WIDTH-1:0]         rem_v_out,
    output logic [lpp_pkg::MAG_WIDTH-1:0]         w_out,
    output logic [PIXEL_INDEX_WIDTH-1:0]          col_out,
    output logic [PIXEL_INDEX_WIDTH-1:0]          row_out,
    output logic [lpp_pkg::SUMSQ_WIDTH-1:0]       s_out,
    output logic [lpp_pkg::RANGE_WIDTH-1:0]       root_out,
    output logic [lpp_pkg::SUMSQ_WIDTH-1:0]       rsq_out
);

    localparam int MW = lpp_pkg::MAG_WIDTH;
    localparam int DW = MW + PIXEL_INDEX_WIDTH + 1;
    localparam int RW = lpp_pkg::RANGE_WIDTH;
    localparam int SW = lpp_pkg::SUMSQ_WIDTH;

    lpp_pkg::step_flags_t       flags_reg, flags_next;
    logic [MW-1:0]              ru_reg, rv_reg, w_reg, ru_next, rv_next;
    logic [PIXEL_INDEX_WIDTH-1:0] col_reg, row_reg, col_next, row_next;
    logic [SW-1:0]              s_reg, rsq_reg, rsq_next;
    logic [RW-1:0]              root_reg, root_next;

    generate
        if (STAGE <= PIXEL_INDEX_WIDTH) begin : g_div
            localparam int K = PIXEL_INDEX_WIDTH - STAGE;
            logic [DW-1:0] wsh;
            logic          fit_u, fit_v;

            assign wsh   = DW'(w_in) << K;
            assign fit_u = DW'(rem_u_in) >= wsh;
            assign fit_v = DW'(rem_v_in) >= wsh;

            if (K == PIXEL_INDEX_WIDTH) begin : g_range
                always_comb begin
                    flags_next = flags_in;
                    ru_next    = rem_u_in;
                    rv_next    = rem_v_in;
                    col_next   = col_in;
                    row_next   = row_in;
                    // quotient at or above the index range: drop the pixel
                    if (fit_u) flags_next.col_ok = 1'b0;
                    if (fit_v) flags_next.row_ok = 1'b0;
                end
            end else begin : g_bit
                always_comb begin
                    flags_next = flags_in;
                    ru_next    = rem_u_in;
                    rv_next    = rem_v_in;
                    col_next   = col_in;
                    row_next   = row_in;
                    if (fit_u) begin
                        ru_next     = rem_u_in - wsh[MW-1:0];
                        col_next[K] = 1'b1;
                    end
                    if (fit_v) begin
                        rv_next     = rem_v_in - wsh[MW-1:0];
                        row_next[K] = 1'b1;
                    end
                end
            end
        end else begin : g_div_pass
            always_comb begin
                flags_next = flags_in;
                ru_next    = rem_u_in;
                rv_next    = rem_v_in;
                col_next   = col_in;
                row_next   = row_in;
            end
        end

        if (STAGE < RW) begin : g_root
            localparam int B = RW - 1 - STAGE;
            logic [SW:0] trial;

            assign trial = {1'b0, rsq_in} + ((SW+1)'(root_in) << (B + 1))
                         + ((SW+1)'(1) << (2 * B));

            always_comb begin
                root_next = root_in;
                rsq_next  = rsq_in;
                if (trial <= {1'b0, s_in}) begin
                    root_next[B] = 1'b1;
                    rsq_next     = trial[SW-1:0];
                end
            end
        end else begin : g_root_pass
            assign root_next = root_in;
            assign rsq_next  = rsq_in;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (en) begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ru_reg   <= ru_next;
            rv_reg   <= rv_next;
            w_reg    <= w_in;
            col_reg  <= col_next;
            row_reg  <= row_next;
            s_reg    <= s_in;
            root_reg <= root_next;
            rsq_reg  <= rsq_next;
        end
    end

    assign flags_out = flags_reg;
    assign rem_u_out = ru_reg;
    assign rem_v_out = rv_reg;
    assign w_out     = w_reg;
    assign col_out   = col_reg;
    assign row_out   = row_reg;
    assign s_out     = s_reg;
    assign root_out  = root_reg;
    assign rsq_out   = rsq_reg;

endmodule

/* hw/rtl/lidar_point_to_pixel_depth.sv */
// Path: front stages, divide and root step stages, then the output register.
// Throughput: one point per cycle; the whole pipeline advances together and
// holds while a finished result waits on m_ready.
// Reset: synchronous active-low; clears all valid bits and loads default
// image size 1920x1080 with zero projection coefficients.
// ----------------------------------------------------------------------------
// lidar_point_to_pixel_depth
// Projects a lidar point onto camera pixel coordinates and computes its range.
// ----------------------------------------------------------------------------
module lidar_point_to_pixel_depth #(
    parameter int COORD_WIDTH       = lpp_pkg::COORD_WIDTH_DEF,
    parameter int PIXEL_INDEX_WIDTH = lpp_pkg::PIXEL_INDEX_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [lpp_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [63:0]                           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [COORD_WIDTH-1:0]         s_point_x_mm,
    input  logic signed [COORD_WIDTH-1:0]         s_point_y_mm,
    input  logic signed [COORD_WIDTH-1:0]         s_point_z_mm,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [PIXEL_INDEX_WIDTH-1:0]          m_pixel_col,
    output logic [PIXEL_INDEX_WIDTH-1:0]          m_pixel_row,
    output logic [lpp_pkg::RANGE_WIDTH-1:0]       m_range_mm,
    output logic                                  m_in_image,
    output logic                                  m_range_saturated
);

    localparam int NSTEP = (PIXEL_INDEX_WIDTH + 1 > lpp_pkg::RANGE_WIDTH) ?
                           PIXEL_INDEX_WIDTH + 1 : lpp_pkg::RANGE_WIDTH;
    localparam int LW = (PIXEL_INDEX_WIDTH > lpp_pkg::SIZE_WIDTH) ?
                        PIXEL_INDEX_WIDTH + 1 : lpp_pkg::SIZE_WIDTH + 1;
    localparam int MW = lpp_pkg::MAG_WIDTH;
    localparam int SW = lpp_pkg::SUMSQ_WIDTH;
    localparam int RW = lpp_pkg::RANGE_WIDTH;

    lpp_pkg::proj_coef_t                coef_reg;
    logic [lpp_pkg::SIZE_WIDTH-1:0]     width_reg, height_reg;

    logic                               en;

    lpp_pkg::step_flags_t               st_flags [NSTEP+1];
    logic [MW-1:0]                      st_ru [NSTEP+1];
    logic [MW-1:0]                      st_rv [NSTEP+1];
    logic [MW-1:0]                      st_w [NSTEP+1];
    logic [PIXEL_INDEX_WIDTH-1:0]       st_col [NSTEP+1];
    logic [PIXEL_INDEX_WIDTH-1:0]       st_row [NSTEP+1];
    logic [SW-1:0]                      st_s [NSTEP+1];
    logic [RW-1:0]                      st_root [NSTEP+1];
    logic [SW-1:0]                      st_rsq [NSTEP+1];

    logic                               out_valid_reg;
    logic [PIXEL_INDEX_WIDTH-1:0]       out_col_reg, out_row_reg;
    logic [RW-1:0]                      out_range_reg;
    logic                               out_in_reg, out_sat_reg;
    logic                               in_next;
    lpp_pkg::step_flags_t               last_f;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg   <= '0;
            width_reg  <= lpp_pkg::WIDTH_RESET;
            height_reg <= lpp_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lpp_pkg::REG_U_XY:   coef_reg[0] <= cfg_wdata;
                lpp_pkg::REG_U_ZO:   coef_reg[1] <= cfg_wdata;
                lpp_pkg::REG_V_XY:   coef_reg[2] <= cfg_wdata;
                lpp_pkg::REG_V_ZO:   coef_reg[3] <= cfg_wdata;
                lpp_pkg::REG_W_XY:   coef_reg[4] <= cfg_wdata;
                lpp_pkg::REG_W_ZO:   coef_reg[5] <= cfg_wdata;
                lpp_pkg::REG_WIDTH:  width_reg   <= cfg_wdata[lpp_pkg::SIZE_WIDTH-1:0];
                lpp_pkg::REG_HEIGHT: height_reg  <= cfg_wdata[lpp_pkg::SIZE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    lpp_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .px        (s_point_x_mm),
        .py        (s_point_y_mm),
        .pz        (s_point_z_mm),
        .coef      (coef_reg),
        .flags_out (st_flags[0]),
        .rem_u     (st_ru[0]),
        .rem_v     (st_rv[0]),
        .div_w     (st_w[0]),
        .sumsq     (st_s[0])
    );

    assign st_col[0]  = '0;
    assign st_row[0]  = '0;
    assign st_root[0] = '0;
    assign st_rsq[0]  = '0;

    generate
        for (genvar i = 0; i < NSTEP; i++) begin : g_step
            lpp_step #(
                .PIXEL_INDEX_WIDTH (PIXEL_INDEX_WIDTH),
                .STAGE             (i)
            ) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .flags_in  (st_flags[i]),
                .rem_u_in  (st_ru[i]),
                .rem_v_in  (st_rv[i]),
                .w_in      (st_w[i]),
                .col_in    (st_col[i]),
                .row_in    (st_row[i]),
                .s_in      (st_s[i]),
                .root_in   (st_root[i]),
                .rsq_in    (st_rsq[i]),
                .flags_out (st_flags[i+1]),
                .rem_u_out (st_ru[i+1]),
                .rem_v_out (st_rv[i+1]),
                .w_out     (st_w[i+1]),
                .col_out   (st_col[i+1]),
                .row_out   (st_row[i+1]),
                .s_out     (st_s[i+1]),
                .root_out  (st_root[i+1]),
                .rsq_out   (st_rsq[i+1])
            );
        end
    endgenerate

    assign last_f  = st_flags[NSTEP];
    assign in_next = last_f.col_ok && last_f.row_ok
                  && (LW'(st_col[NSTEP]) < LW'(width_reg))
                  && (LW'(st_row[NSTEP]) < LW'(height_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= last_f.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_in_reg    <= in_next;
            out_col_reg   <= in_next ? st_col[NSTEP] : '0;
            out_row_reg   <= in_next ? st_row[NSTEP] : '0;
            out_sat_reg   <= last_f.sat;
            out_range_reg <= last_f.sat ? {RW{1'b1}} : st_root[NSTEP];
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_pixel_col       = out_col_reg;
    assign m_pixel_row       = out_row_reg;
    assign m_range_mm        = out_range_reg;
    assign m_in_image        = out_in_reg;
    assign m_range_saturated = out_sat_reg;

endmodule

/* hw/rtl/lpp_checker.sv */
// ----------------------------------------------------------------------------
// lpp_checker
// Port-level checks on the result channel of the projection pipeline.
// ----------------------------------------------------------------------------
module lpp_checker #(
    parameter int PIXEL_INDEX_WIDTH = lpp_pkg::PIXEL_INDEX_WIDTH_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [PIXEL_INDEX_WIDTH-1:0]     m_pixel_col,
    input logic [PIXEL_INDEX_WIDTH-1:0]     m_pixel_row,
    input logic [lpp_pkg::RANGE_WIDTH-1:0]  m_range_mm,
    input logic                             m_in_image,
    input logic                             m_range_saturated
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_range_mm) && $stable(m_pixel_col)
            && $stable(m_in_image))
        else $error("result changed while stalled");

    a_off_image_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_image |-> m_pixel_col == '0 && m_pixel_row == '0)
        else $error("off-image pixel not zeroed");

    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_saturated |-> m_range_mm == {lpp_pkg::RANGE_WIDTH{1'b1}})
        else $error("saturated range not clamped");

endmodule

bind lidar_point_to_pixel_depth lpp_checker #(
    .PIXEL_INDEX_WIDTH (PIXEL_INDEX_WIDTH)
) u_lpp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_pixel_col       (m_pixel_col),
    .m_pixel_row       (m_pixel_row),
    .m_range_mm        (m_range_mm),
    .m_in_image        (m_in_image),
    .m_range_saturated (m_range_saturated)
);

/* bench/lidar_point_to_pixel_depth_test.sv */
// ----------------------------------------------------------------------------
// lidar_point_to_pixel_depth_test
// Drives lidar points through the projection block under random handshake
// gaps and stalls, predicts pixel, range and flags per point, and compares.
// ----------------------------------------------------------------------------
module lidar_point_to_pixel_depth_test;

    localparam int CW = lpp_pkg::COORD_WIDTH_DEF;
    localparam int PW = lpp_pkg::PIXEL_INDEX_WIDTH_DEF;
    localparam int IW = lpp_pkg::CFG_IDX_WIDTH;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [PW-1:0] col;
        logic [PW-1:0] row;
        logic [15:0]   range;
        logic          in_img;
        logic          sat;
    } pixel_depth_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_point_x_mm = '0;
    logic signed [CW-1:0] s_point_y_mm = '0;
    logic signed [CW-1:0] s_point_z_mm = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [PW-1:0] m_pixel_col, m_pixel_row;
    logic [15:0] m_range_mm;
    logic m_in_image, m_range_saturated;

    logic [63:0] proj_coef [6];
    logic [12:0] img_w, img_h;
    pixel_depth_t expected_q [$];
    int errors = 0;
    int points_sent = 0;
    int points_in_image = 0;
    int points_saturated = 0;
    int idle_cycles = 0;
    int gap_mode = 1;
    int stall_mode = 1;

    lidar_point_to_pixel_depth i_dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Signed Q20.12 weight from one half of a coefficient register.
    function automatic longint coef_half(input logic [63:0] r, input bit hi);
        logic [31:0] h;
        h = hi ? r[63:32] : r[31:0];
        return longint'(signed'(h));
    endfunction

    function automatic longint homog(input int k, input longint cx, input longint cy,
                                     input longint cz);
        return cx * coef_half(proj_coef[2*k], 0) + cy * coef_half(proj_coef[2*k], 1)
             + cz * coef_half(proj_coef[2*k+1], 0) + coef_half(proj_coef[2*k+1], 1);
    endfunction

    function automatic pixel_depth_t project_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                                   input logic [CW-1:0] z);
        pixel_depth_t p;
        longint px, py, pz, u, v, w, c, r, wl, hl;
        longint unsigned sum, rt, t;
        px = longint'(signed'(x));
        py = longint'(signed'(y));
        pz = longint'(signed'(z));
        u = homog(0, -py, -pz, px);
        v = homog(1, -py, -pz, px);
        w = homog(2, -py, -pz, px);
        wl = (img_w < (1 << PW)) ? img_w : (1 << PW);
        hl = (img_h < (1 << PW)) ? img_h : (1 << PW);
        p = '0;
        if (w > 0) begin
            c = u / w;
            r = v / w;
            if (c >= 0 && r >= 0 && c < wl && r < hl) begin
                p.col = c[PW-1:0];
                p.row = r[PW-1:0];
                p.in_img = 1'b1;
            end
        end
        sum = px * px + py * py + pz * pz;
        if (sum > 64'd4294836225) begin
            p.range = 16'hFFFF;
            p.sat = 1'b1;
        end else begin
            rt = 0;
            for (int b = 15; b >= 0; b--) begin
                t = rt | (64'd1 << b);
                if (t * t <= sum) rt = t;
            end
            p.range = rt[15:0];
        end
        return p;
    endfunction

    task automatic write_reg(input logic [IW-1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx <= lpp_pkg::REG_W_ZO) proj_coef[idx] = val;
        else if (idx == lpp_pkg::REG_WIDTH) img_w = val[12:0];
        else if (idx == lpp_pkg::REG_HEIGHT) img_h = val[12:0];
    endtask

    task automatic wait_idle();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Pinhole camera: integer fx, fy, cx, cy written as Q.12 weights; w = depth.
    task automatic load_camera(input int fx, input int fy, input int ccx, input int ccy,
                               input logic [12:0] wd, input logic [12:0] ht);
        wait_idle();
        write_reg(lpp_pkg::REG_U_XY, {32'd0, 32'(fx << 12)});
        write_reg(lpp_pkg::REG_U_ZO, {32'd0, 32'(ccx << 12)});
        write_reg(lpp_pkg::REG_V_XY, {32'(fy << 12), 32'd0});
        write_reg(lpp_pkg::REG_V_ZO, {32'd0, 32'(ccy << 12)});
        write_reg(lpp_pkg::REG_W_XY, 64'd0);
        write_reg(lpp_pkg::REG_W_ZO, {32'd0, 32'(1 << 12)});
        write_reg(lpp_pkg::REG_WIDTH, {51'd0, wd});
        write_reg(lpp_pkg::REG_HEIGHT, {51'd0, ht});
    endtask

    task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z);
        s_valid <= 1'b1;
        s_point_x_mm <= x;
        s_point_y_mm <= y;
        s_point_z_mm <= z;
        expected_q = {expected_q, project_point(x, y, z)};
        do @(posedge aclk); while (!s_ready);
        points_sent++;
        if (gap_mode != 0 && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return logic'($urandom) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            1: return CW'($urandom_range(0, 30000));
            2: return -CW'($urandom_range(0, 30000));
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        // All-zero coefficients: divisor zero, only range matters.
        send_point('0, '0, '0);
        send_point({1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}});
        send_point({1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}});
        send_point(CW'(65535), '0, '0);
        send_point(CW'(65535), CW'(1), '0);
        send_point(CW'(3), -CW'(4), '0);
        end_burst();
    endtask

    task automatic test_directed_projection();
        load_camera(1000, 1000, 960, 540, 13'd1920, 13'd1080);
        send_point(CW'(5000), '0, '0);          // image center
        send_point(-CW'(5000), '0, '0);         // behind camera
        send_point('0, '0, '0);                 // zero divisor
        send_point(CW'(1000), CW'(2000), '0);   // off left
        send_point(CW'(1000), -CW'(2000), '0);  // off right
        send_point(CW'(1000), '0, CW'(600));    // off top
        send_point(CW'(1000), '0, -CW'(600));   // off bottom
        send_point(CW'(1000), CW'(960), CW'(540));
        send_point(CW'(1000), -CW'(959), -CW'(539));
        end_burst();
        // Extreme weights and sizes, including oversize and zero dimensions.
        wait_idle();
        write_reg(lpp_pkg::REG_U_XY, 64'h8000_0000_7FFF_FFFF);
        write_reg(lpp_pkg::REG_U_ZO, 64'h7FFF_FFFF_8000_0000);
        write_reg(lpp_pkg::REG_WIDTH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(lpp_pkg::REG_HEIGHT, 64'd0);
        send_point(CW'(100), CW'(5), CW'(7));
        end_burst();
        wait_idle();
        write_reg(4'd8, 64'hFFFF);            // unknown index: no effect
        wait_idle();
        write_reg(4'd15, 64'd1);
        write_reg(lpp_pkg::REG_HEIGHT, 64'd4096);
        write_reg(lpp_pkg::REG_WIDTH, 64'd4096);
        load_camera(1, 1, 4095, 4095, 13'd4096, 13'd4096);
        send_point(CW'(1), '0, '0);
        send_point(CW'(1), CW'(1), CW'(1));
    endtask

    task automatic test_random_points(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 300 == 0) begin
                end_burst();
                case ((i / 300) % 4)
                    0: load_camera($urandom_range(1, 2000), $urandom_range(1, 2000),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                                   13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
                    1: load_camera(500, 500, 320, 240, 13'd640, 13'd480);
                    default: begin
                        wait_idle();
                        for (int k = 0; k < 6; k++)
                            write_reg(IW'(k), {$urandom, $urandom});
                        write_reg(lpp_pkg::REG_WIDTH, {$urandom, $urandom});
                        write_reg(lpp_pkg::REG_HEIGHT, {$urandom, $urandom});
                    end
                endcase
                gap_mode = $urandom_range(0, 1);
                stall_mode = $urandom_range(0, 2);
            end
            if (i % 3 == 0)
                send_point(CW'($urandom_range(500, 60000)),
                           CW'(int'($urandom_range(0, 8000)) - 4000),
                           CW'(int'($urandom_range(0, 6000)) - 3000));
            else
                send_point(rand_coord(), rand_coord(), rand_coord());
        end
        end_burst();
    endtask

    // Receiver stall pattern.
    always @(posedge aclk) begin
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 7) < 3);
        endcase
    end

    always @(posedge aclk) begin
        pixel_depth_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no point pending");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_pixel_col !== e.col) begin
                    $error("pixel_col exp %0d got %0d", e.col, m_pixel_col); errors++;
                end
                if (m_pixel_row !== e.row) begin
                    $error("pixel_row exp %0d got %0d", e.row, m_pixel_row); errors++;
                end
                if (m_range_mm !== e.range) begin
                    $error("range_mm exp %0d got %0d", e.range, m_range_mm); errors++;
                end
                if (m_in_image !== e.in_img) begin
                    $error("in_image exp %0d got %0d", e.in_img, m_in_image); errors++;
                end
                if (m_range_saturated !== e.sat) begin
                    $error("range_saturated exp %0d got %0d", e.sat, m_range_saturated);
                    errors++;
                end
                points_in_image += e.in_img;
                points_saturated += e.sat;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lidar_point_to_pixel_depth test failed");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 6; k++) proj_coef[k] = '0;
        img_w = lpp_pkg::WIDTH_RESET;
        img_h = lpp_pkg::HEIGHT_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_projection();
        test_random_points(1200);
        wait_idle();
        if (expected_q.size() != 0) errors++;
        $display("Sent %0d points over several camera setups; %0d landed in the image,",
                 points_sent, points_in_image);
        $display("%0d had saturated range.", points_saturated);
        if (errors == 0) $display("lidar_point_to_pixel_depth test passed");
        else $display("lidar_point_to_pixel_depth test failed");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/lpp_pkg.sv
hw/rtl/lpp_front.sv
hw/rtl/lpp_step.sv
hw/rtl/lidar_point_to_pixel_depth.sv
hw/rtl/lpp_checker.sv
bench/lidar_point_to_pixel_depth_test.sv
